/* rtl/core/dobq_pkg.sv */
// Shared types, codes and defaults for the drop-oldest descriptor queue.
package dobq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int SIZE_BITS_DEF = 16;
  localparam int TAG_BITS_DEF  = 16;

  localparam int ME_BITS   = 5;   // max_entries register width
  localparam int BYTE_BITS = 24;  // max_bytes register and byte total width
  localparam int FUNC_BITS = 2;
  localparam int STAT_BITS = 32;

  localparam int MAX_ENTRIES_RST = 16;
  localparam int MAX_BYTES_RST   = 1048576;

  typedef enum logic [0:0] {
    REG_MAX_ENTRIES = 1'b0,
    REG_MAX_BYTES   = 1'b1
  } reg_index_t;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_DRAIN  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_RSTATS = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DROP  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

endpackage

/* rtl/core/drop_oldest_byte_bounded_queue.sv */
// Drop-oldest FIFO of packet descriptors bounded by entry and byte limits.
//
// Usage:
//   Requests enter on s_tvalid/s_tready: s_tuser carries the function (push,
//   drain all, clear queue, reset statistics), s_tdata the tag and size of a
//   pushed packet. Results leave on m_tvalid/m_tready; m_tlast marks the final
//   result of a request, m_tuser carries the entry-valid and kept-all flags,
//   m_tdata the descriptor, occupancy and statistics.
//   A push without displacement, a clear and a reset-stats each go from IDLE
//   to EMIT and back. Each displaced entry adds a DROP and a CHECK state (head
//   read from the descriptor memory, then the byte-total update and a fresh
//   limit check). A drain reads its entries in order through the single
//   registered read port, prefetching each one as the one before it leaves,
//   and waits while the output register is held by a stalled receiver.
//   Reset (rst, synchronous) empties the queue, zeroes the statistics and
//   loads the limit registers with 16 entries and 1 MiB. Memory contents are
//   not cleared; only pushed entries are ever used.
//   A stalled receiver holds the output register; the next request is still
//   accepted and runs until it needs the output register, then it waits.
//   Write cfg_index/cfg_data with cfg_wen only while the block is idle.
module drop_oldest_byte_bounded_queue #(
  parameter int DEPTH     = dobq_pkg::DEPTH_DEF,
  parameter int SIZE_BITS = dobq_pkg::SIZE_BITS_DEF,
  parameter int TAG_BITS  = dobq_pkg::TAG_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int IN_W     = ((TAG_BITS + SIZE_BITS + 7) / 8) * 8,
  localparam int OUT_RAW  = TAG_BITS + SIZE_BITS + 2 * CNT_W + 3 * dobq_pkg::STAT_BITS,
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_wen,
  input  logic                              cfg_index,
  input  logic [dobq_pkg::BYTE_BITS-1:0]    cfg_data,
  // request channel
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [IN_W-1:0]                   s_tdata,  // packet_tag, packet_size
  input  logic [dobq_pkg::FUNC_BITS-1:0]    s_tuser,  // func
  // result channel
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_tag, out_size, occupancy, pushed_count, dropped_count, drained_count,
  // high_water
  output logic [OUT_W-1:0]                  m_tdata,
  output logic                              m_tlast,  // last
  output logic [1:0]                        m_tuser   // entry_valid, kept_all
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENT_W = TAG_BITS + SIZE_BITS;
  localparam int CMP_W = (CNT_W > dobq_pkg::ME_BITS) ? CNT_W : dobq_pkg::ME_BITS;
  localparam int BB    = dobq_pkg::BYTE_BITS;
  localparam int SB    = dobq_pkg::STAT_BITS;

  // limit registers
  logic [dobq_pkg::ME_BITS-1:0] max_entries;
  logic [BB-1:0]                max_bytes;

  // queue control state
  dobq_pkg::state_t state;
  logic [PTR_W-1:0] head_ptr, tail_ptr, rd_ptr;
  logic [CNT_W-1:0] entry_count, remaining, peak_count;
  logic [BB-1:0]    byte_total;
  logic [SB-1:0]    pushes, drops, drains;

  // latched request
  logic [TAG_BITS-1:0]  tag_q;
  logic [SIZE_BITS-1:0] size_q;
  logic                 kept_q;

  // descriptor memory
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] rd_addr;
  logic [ENT_W-1:0] wr_data;

  // output register
  logic                 o_valid_e, o_kept;
  logic [TAG_BITS-1:0]  o_tag;
  logic [SIZE_BITS-1:0] o_size;
  logic [CNT_W-1:0]     o_occ, o_peak;
  logic [SB-1:0]        o_push, o_drop, o_drain;

  logic                 in_fire, out_free, do_push, o_load;
  logic                 drop_in, drop_chk;
  dobq_pkg::func_t      in_func;
  logic [TAG_BITS-1:0]  in_tag;
  logic [SIZE_BITS-1:0] in_size, push_size;
  logic [SIZE_BITS-1:0] rd_size;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // One more entry or its bytes would break a limit while entries remain.
  function automatic logic must_drop(input logic [CNT_W-1:0] cnt,
                                     input logic [BB-1:0] total,
                                     input logic [SIZE_BITS-1:0] sz,
                                     input logic [dobq_pkg::ME_BITS-1:0] me,
                                     input logic [BB-1:0] mb);
    logic ent_break, byte_break;
    ent_break  = (CMP_W'(cnt) >= CMP_W'(me)) || (cnt == CNT_W'(DEPTH));
    byte_break = ((BB + 1)'(total) + (BB + 1)'(sz)) > (BB + 1)'(mb);
    must_drop  = (cnt != '0) && (ent_break || byte_break);
  endfunction

  assign in_func  = dobq_pkg::func_t'(s_tuser);
  assign in_tag   = s_tdata[TAG_BITS-1:0];
  assign in_size  = s_tdata[ENT_W-1:TAG_BITS];
  assign rd_size  = rd_data[ENT_W-1:TAG_BITS];
  assign s_tready = (state == dobq_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign o_load   = out_free &&
                    (state == dobq_pkg::ST_EMIT || state == dobq_pkg::ST_DRAIN);

  always_comb begin
    drop_in  = must_drop(entry_count, byte_total, in_size, max_entries, max_bytes);
    drop_chk = must_drop(entry_count, byte_total, size_q, max_entries, max_bytes);
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    rd_addr  = head_ptr;
    if (state == dobq_pkg::ST_IDLE) begin
      wr_data   = {in_size, in_tag};
      push_size = in_size;
    end else begin
      wr_data   = {size_q, tag_q};
      push_size = size_q;
    end
    unique case (state)
      dobq_pkg::ST_IDLE: begin
        if (in_fire && in_func == dobq_pkg::FUNC_PUSH) begin
          mem_we = !drop_in;
          mem_re = drop_in;
        end else if (in_fire && in_func == dobq_pkg::FUNC_DRAIN) begin
          mem_re = (entry_count != '0);
        end
      end
      dobq_pkg::ST_CHECK: begin
        mem_we = !drop_chk;
        mem_re = drop_chk;
      end
      dobq_pkg::ST_DRAIN: begin
        // prefetch the following entry as the current one leaves
        mem_re  = out_free;
        rd_addr = next_slot(rd_ptr);
      end
      dobq_pkg::ST_DROP, dobq_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
    do_push = mem_we;
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_ptr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= dobq_pkg::ME_BITS'(dobq_pkg::MAX_ENTRIES_RST);
      max_bytes   <= BB'(dobq_pkg::MAX_BYTES_RST);
    end else if (cfg_wen) begin
      unique case (dobq_pkg::reg_index_t'(cfg_index))
        dobq_pkg::REG_MAX_ENTRIES: max_entries <= cfg_data[dobq_pkg::ME_BITS-1:0];
        dobq_pkg::REG_MAX_BYTES:   max_bytes   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dobq_pkg::ST_IDLE;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      entry_count <= '0;
      byte_total  <= '0;
      pushes      <= '0;
      drops       <= '0;
      drains      <= '0;
      peak_count  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // present a freshly loaded result, else free the register once taken
      if (o_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // commit a push: write already issued to the memory
      if (do_push) begin
        tail_ptr    <= next_slot(tail_ptr);
        entry_count <= entry_count + 1'b1;
        byte_total  <= byte_total + BB'(push_size);
        pushes      <= pushes + 1'b1;
        if (entry_count + 1'b1 > peak_count) begin
          peak_count <= entry_count + 1'b1;
        end
        state  <= dobq_pkg::ST_EMIT;
      end

      unique case (state)
        dobq_pkg::ST_IDLE: begin
          if (in_fire) begin
            tag_q  <= in_tag;
            size_q <= in_size;
            // only a push that displaces nothing keeps all
            kept_q <= (in_func == dobq_pkg::FUNC_PUSH) && !drop_in;
            unique case (in_func)
              dobq_pkg::FUNC_PUSH: begin
                if (drop_in) begin
                  state <= dobq_pkg::ST_DROP;
                end
              end
              dobq_pkg::FUNC_DRAIN: begin
                if (entry_count == '0) begin
                  state <= dobq_pkg::ST_EMIT;
                end else begin
                  drains      <= drains + SB'(entry_count);
                  remaining   <= entry_count;
                  rd_ptr      <= head_ptr;
                  head_ptr    <= tail_ptr;
                  entry_count <= '0;
                  byte_total  <= '0;
                  state       <= dobq_pkg::ST_DRAIN;
                end
              end
              dobq_pkg::FUNC_CLEAR: begin
                entry_count <= '0;
                byte_total  <= '0;
                head_ptr    <= tail_ptr;
                state       <= dobq_pkg::ST_EMIT;
              end
              dobq_pkg::FUNC_RSTATS: begin
                pushes     <= '0;
                drops      <= '0;
                drains     <= '0;
                peak_count <= '0;
                state      <= dobq_pkg::ST_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        dobq_pkg::ST_DROP: begin
          // head entry is in rd_data: displace it
          byte_total  <= byte_total - BB'(rd_size);
          head_ptr    <= next_slot(head_ptr);
          entry_count <= entry_count - 1'b1;
          drops       <= drops + 1'b1;
          state       <= dobq_pkg::ST_CHECK;
        end
        dobq_pkg::ST_CHECK: begin
          if (drop_chk) begin
            state <= dobq_pkg::ST_DROP;
          end
        end
        dobq_pkg::ST_EMIT: begin
          if (out_free) begin
            o_valid_e <= 1'b0;
            o_tag     <= '0;
            o_size    <= '0;
            m_tlast   <= 1'b1;
            o_kept    <= kept_q;
            o_occ     <= entry_count;
            o_push    <= pushes;
            o_drop    <= drops;
            o_drain   <= drains;
            o_peak    <= peak_count;
            state     <= dobq_pkg::ST_IDLE;
          end
        end
        dobq_pkg::ST_DRAIN: begin
          if (out_free) begin
            o_valid_e <= 1'b1;
            o_tag     <= rd_data[TAG_BITS-1:0];
            o_size    <= rd_size;
            m_tlast   <= (remaining == CNT_W'(1));
            o_kept    <= 1'b0;
            o_occ     <= entry_count;
            o_push    <= pushes;
            o_drop    <= drops;
            o_drain   <= drains;
            o_peak    <= peak_count;
            rd_ptr    <= next_slot(rd_ptr);
            remaining <= remaining - 1'b1;
            if (remaining == CNT_W'(1)) begin
              state <= dobq_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state <= dobq_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = OUT_W'({o_peak, o_drain, o_drop, o_push, o_occ, o_size, o_tag});
  assign m_tuser = {o_kept, o_valid_e};

endmodule
